[sv/socb_pkg.sv]
// Package for the source-over constant color blend unit.
// Shared constants, register codes, path codes, stage enables and blend helpers.
// No dependencies.
package socb_pkg;

   localparam int ALPHA_SHIFT = 24;
   localparam int ALPHA_LANE  = (ALPHA_SHIFT / 8) % 4;
   localparam int NUM_LANES   = 4;
   localparam int CHAN_W      = 8;
   localparam int PIXEL_W     = NUM_LANES * CHAN_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   // word index of a csr, taken from paddr[2]
   typedef enum logic [0:0] {
      CSR_COLOR = 1'b0,
      CSR_MODE  = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      PATH_ROW   = 2'd0,
      PATH_LERP  = 2'd1,
      PATH_SCALE = 2'd2
   } path_type;

   // load enables of the four pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   // (x * 257) >> 16, x already carries the +128 rounding term
   function automatic logic [9:0] mul257_hi(input logic [16:0] x);
      logic [25:0] w;
      w = {9'd0, x} + {1'b0, x, 8'd0};
      return w[25:16];
   endfunction

   function automatic logic [CHAN_W-1:0] sat255(input logic [9:0] x);
      return (x > 10'd255) ? CHAN_MAX : x[CHAN_W-1:0];
   endfunction

endpackage

[sv/socb_lane.sv]
// One byte channel of the blend datapath, four register stages deep.
// Depends on socb_pkg (path codes, stage enables, mul257_hi, sat255).
module socb_lane (
   input  logic                  clock,
   input  socb_pkg::stage_en_type en,
   input  logic [7:0]            src_chan,
   input  logic [7:0]            src_alpha,
   input  logic [7:0]            dest_chan,
   input  logic [7:0]            coverage,
   input  socb_pkg::path_type    path_s1,
   input  socb_pkg::path_type    path_s3,
   input  logic [7:0]            sc_alpha,
   output logic [7:0]            sc_s2,
   output logic [7:0]            result
);
   import socb_pkg::*;

   // stage 1: products
   logic [15:0] psc_ff, pla_ff, plb_ff, prs_ff, prd_ff;
   logic [15:0] psc_in, pla_in, plb_in, prs_in, prd_in;
   logic [7:0]  dc1_ff;
   // stage 2: scaled source and the row / lerp sum
   logic [7:0]  sc2_ff, sc2_in, dc2_ff;
   logic [16:0] x2_ff, x2_in;
   // stage 3: row / lerp quotient, dest times inverse scaled alpha
   logic [9:0]  rdiv3_ff, rdiv3_in;
   logic [7:0]  sc3_ff;
   logic [15:0] prod3_ff, prod3_in;
   // stage 4: saturated result
   logic [9:0]  sum4;
   logic [9:0]  res4;
   logic [7:0]  out4_ff, out4_in;

   always_comb begin
      psc_in = {8'd0, src_chan} * {8'd0, coverage};
      pla_in = {8'd0, CHAN_MAX - coverage} * {8'd0, dest_chan};
      plb_in = {8'd0, coverage} * {8'd0, src_chan};
      prs_in = {8'd0, src_chan} * 16'd255 + 16'd128;
      prd_in = {8'd0, dest_chan} * {8'd0, CHAN_MAX - src_alpha};
   end

   always_comb begin
      sc2_in = sat255(mul257_hi({1'b0, psc_ff} + 17'd128));
      if (path_s1 == PATH_ROW) begin
         x2_in = {1'b0, prs_ff} + {1'b0, prd_ff};
      end else begin
         x2_in = {1'b0, pla_ff} + {1'b0, plb_ff} + 17'd128;
      end
   end

   always_comb begin
      rdiv3_in = mul257_hi(x2_ff);
      prod3_in = {8'd0, dc2_ff} * {8'd0, CHAN_MAX - sc_alpha};
   end

   always_comb begin
      sum4 = {2'd0, sc3_ff} + mul257_hi({1'b0, prod3_ff} + 17'd128);
      res4 = (path_s3 == PATH_SCALE) ? sum4 : rdiv3_ff;
      out4_in = sat255(res4);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         psc_ff <= psc_in;
         pla_ff <= pla_in;
         plb_ff <= plb_in;
         prs_ff <= prs_in;
         prd_ff <= prd_in;
         dc1_ff <= dest_chan;
      end
      if (en.s2) begin
         sc2_ff <= sc2_in;
         x2_ff  <= x2_in;
         dc2_ff <= dc1_ff;
      end
      if (en.s3) begin
         rdiv3_ff <= rdiv3_in;
         sc3_ff   <= sc2_ff;
         prod3_ff <= prod3_in;
      end
      if (en.s4) begin
         out4_ff <= out4_in;
      end
   end

   assign sc_s2  = sc2_ff;
   assign result = out4_ff;

endmodule

[sv/src_over_constant_color_blend_unit.sv]
// Top level of the source-over constant color blend unit.
// Depends on socb_pkg and socb_lane.
//
// Blends the premultiplied color in csr source_color onto a stream of destination
// pixels, one word per pixel. Each word passes through the four-stage datapath
// (multiply, sum and scale, divide by 255, add and saturate) that every channel
// runs in parallel; the rate is one pixel per clock while the output is not
// stalled. Bubbles between stages are filled while the output is stalled.
// full_coverage_mode = 1 blends whole rows and ignores coverage. Write the csrs only
// while no word is in flight.
module src_over_constant_color_blend_unit (
   input  logic                           clock,
   input  logic                           reset,
   // slave side
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [39:0]                    req_tdata,   // dest_pixel[31:0], coverage[39:32]
   input  logic                           req_tlast,   // row_end
   input  logic                           req_tuser,   // block_end
   // master side
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // blended_pixel[31:0]
   output logic                           rsp_tlast,   // row_end_out
   output logic                           rsp_tuser,   // block_end_out
   // csr port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [socb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [socb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [socb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import socb_pkg::*;

   logic [PIXEL_W-1:0] color_ff, color_in;
   logic               mode_ff, mode_in;
   logic               csr_wr;
   csr_reg_type        csr_sel;

   logic [7:0]         src_alpha;
   logic [7:0]         cov_in;
   logic [PIXEL_W-1:0] dest_in;
   path_type           path_in;
   path_type           path1_ff, path2_ff, path3_ff;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic               v1_in, v2_in, v3_in, v4_in;
   logic               rdy1, rdy2, rdy3, rdy4;
   stage_en_type       en;

   logic [3:0]         last_ff, user_ff;

   logic [7:0]         sc_s2 [NUM_LANES];
   logic [7:0]         lane_out [NUM_LANES];

   // csr access
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      color_in = color_ff;
      mode_in  = mode_ff;
      if (csr_wr) begin
         case (csr_sel)
            CSR_COLOR: color_in = csr_pwdata[PIXEL_W-1:0];
            CSR_MODE:  mode_in  = csr_pwdata[0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_COLOR: csr_prdata = color_ff;
         CSR_MODE:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // pipeline flow: a stage loads when it is empty or its successor moves
   always_comb begin
      rdy4 = !v4_ff || rsp_tready;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      en.s1 = rdy1;
      en.s2 = rdy2;
      en.s3 = rdy3;
      en.s4 = rdy4;
      v1_in = rdy1 ? req_tvalid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
   end

   assign req_tready = rdy1;

   assign dest_in   = req_tdata[PIXEL_W-1:0];
   assign cov_in    = req_tdata[39:32];
   assign src_alpha = color_ff[ALPHA_LANE*CHAN_W +: CHAN_W];

   always_comb begin
      if (mode_ff) begin
         path_in = PATH_ROW;
      end else if (src_alpha == CHAN_MAX) begin
         path_in = PATH_LERP;
      end else begin
         path_in = PATH_SCALE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '0;
         mode_ff  <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
      end else begin
         color_ff <= color_in;
         mode_ff  <= mode_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
      end
   end

   // side bands and path codes ride along with the data
   always_ff @(posedge clock) begin
      if (en.s1) begin
         path1_ff   <= path_in;
         last_ff[0] <= req_tlast;
         user_ff[0] <= req_tuser;
      end
      if (en.s2) begin
         path2_ff   <= path1_ff;
         last_ff[1] <= last_ff[0];
         user_ff[1] <= user_ff[0];
      end
      if (en.s3) begin
         path3_ff   <= path2_ff;
         last_ff[2] <= last_ff[1];
         user_ff[2] <= user_ff[1];
      end
      if (en.s4) begin
         last_ff[3] <= last_ff[2];
         user_ff[3] <= user_ff[2];
      end
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      socb_lane u_lane (
         .clock     (clock),
         .en        (en),
         .src_chan  (color_ff[i*CHAN_W +: CHAN_W]),
         .src_alpha (src_alpha),
         .dest_chan (dest_in[i*CHAN_W +: CHAN_W]),
         .coverage  (cov_in),
         .path_s1   (path1_ff),
         .path_s3   (path3_ff),
         .sc_alpha  (sc_s2[ALPHA_LANE]),
         .sc_s2     (sc_s2[i]),
         .result    (lane_out[i])
      );
      assign rsp_tdata[i*CHAN_W +: CHAN_W] = lane_out[i];
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tlast  = last_ff[3];
   assign rsp_tuser  = user_ff[3];

   // a full pipe with a stalled output must refuse new words
   assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready) |-> !req_tready)
      else $error("pipe full and stalled but input still taken");

   // an accepted word lands in stage 1
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted word lost at stage 1");

   // a valid stage 1 word moves on when stage 2 can load
   assert property (@(posedge clock) disable iff (reset)
      (v1_ff && rdy2) |=> v2_ff)
      else $error("word lost between stage 1 and stage 2");

endmodule

[sim/src_over_constant_color_blend_unit_tb.sv]
// Testbench for src_over_constant_color_blend_unit: directed table, then random pixel
// streams under several idle and stall mixes, each result checked in order.
// Depends on socb_pkg and the RTL of the blend unit.
module src_over_constant_color_blend_unit_tb;
   import socb_pkg::*;

   typedef struct {
      logic [31:0] dest;
      logic [7:0]  coverage;
      logic        row_end;
      logic        block_end;
   } pixel_word_type;

   typedef struct {
      logic [31:0] pixel;
      logic        row_end;
      logic        block_end;
   } blend_word_type;

   typedef struct packed {
      logic [31:0] color;
      logic        row_mode;
      logic [31:0] dest;
      logic [7:0]  coverage;
      logic        row_end;
      logic        block_end;
      logic        hand_checked;  // want holds the result worked out by hand
      logic [31:0] want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 20;
   localparam int SETTINGS_PER_PHASE = 6;
   localparam int PIXELS_PER_SETTING = 65;

   // color, row mode, dest, coverage, row end, block end, hand checked, result
   directed_row_type directed_table [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 1'b0, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 1'b1, 32'h0000_0000},
      '{32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF},
      '{32'h0000_0000, 1'b0, 32'h1234_5678, 8'h80, 1'b0, 1'b1, 1'b1, 32'h1234_5678},
      '{32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{32'hFFFF_FFFF, 1'b0, 32'h89AB_CDEF, 8'h00, 1'b0, 1'b0, 1'b1, 32'h89AB_CDEF},
      '{32'hFFFF_FFFF, 1'b0, 32'h5A5A_5A5A, 8'h7F, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
      '{32'hFF10_2030, 1'b0, 32'hA5C3_E100, 8'h40, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
      // alpha just below opaque takes the scale path
      '{32'hFE80_4020, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
      '{32'hFE80_4020, 1'b0, 32'h0000_0000, 8'h01, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
      // channels above alpha: sums run past 255 and saturate
      '{32'h00FF_FFFF, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF},
      '{32'h00FF_FFFF, 1'b0, 32'h8080_8080, 8'h80, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
      '{32'h10FF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF},
      '{32'h10FF_FFFF, 1'b1, 32'h0102_0304, 8'hFF, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
      '{32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF},
      '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'h80, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{32'h0000_0000, 1'b1, 32'h00FF_00FF, 8'h33, 1'b1, 1'b0, 1'b1, 32'h00FF_00FF},
      '{32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF},
      // 0xFF outside the alpha byte does not make the source opaque
      '{32'h0000_00FF, 1'b0, 32'h1122_3344, 8'hFF, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h7F00_0000, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h7F00_0000, 1'b1, 32'h8080_8080, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0000_0000}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata = '0;   // dest_pixel[31:0], coverage[39:32]
   logic                  req_tlast = 1'b0; // row_end
   logic                  req_tuser = 1'b0; // block_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;        // blended_pixel[31:0]
   logic                  rsp_tlast;        // row_end_out
   logic                  rsp_tuser;        // block_end_out
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [31:0]           cfg_color = '0;
   logic                  cfg_row_mode = 1'b0;
   int                    src_gap_pct = 0;
   int                    rsp_stall_pct = 0;
   int                    mismatch_count = 0;
   blend_word_type        expected_blends [$];

   src_over_constant_color_blend_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned round_div255(input int unsigned x);
      return ((x + 128) * 257) >> 16;
   endfunction

   function automatic logic [7:0] clamp_255(input int unsigned x);
      return (x > 255) ? 8'hFF : x[7:0];
   endfunction

   function automatic logic [31:0] blend_pixel(input logic [31:0] color, input logic row_mode,
                                               input logic [31:0] dest, input logic [7:0] cov);
      int unsigned src_alpha, scaled_alpha, s, d, c, r;
      int          lane;
      logic [31:0] scaled, result;
      src_alpha = 32'(color[ALPHA_LANE*CHAN_W +: CHAN_W]);
      c = 32'(cov);
      for (lane = 0; lane < NUM_LANES; lane++) begin
         s = 32'(color[lane*CHAN_W +: CHAN_W]);
         scaled[lane*CHAN_W +: CHAN_W] = clamp_255(round_div255(s * c));
      end
      scaled_alpha = 32'(scaled[ALPHA_LANE*CHAN_W +: CHAN_W]);
      for (lane = 0; lane < NUM_LANES; lane++) begin
         s = 32'(color[lane*CHAN_W +: CHAN_W]);
         d = 32'(dest[lane*CHAN_W +: CHAN_W]);
         if (row_mode) begin
            r = ((s * 255 + 128 + d * (255 - src_alpha)) * 257) >> 16;
         end else if (src_alpha == 255) begin
            r = round_div255((255 - c) * d + c * s);
         end else begin
            r = 32'(scaled[lane*CHAN_W +: CHAN_W]) + round_div255(d * (255 - scaled_alpha));
         end
         result[lane*CHAN_W +: CHAN_W] = clamp_255(r);
      end
      return result;
   endfunction

   function automatic pixel_word_type random_pixel();
      pixel_word_type px;
      case ($urandom_range(15))
         0:       px.dest = 32'h0000_0000;
         1:       px.dest = 32'hFFFF_FFFF;
         default: px.dest = $urandom;
      endcase
      case ($urandom_range(7))
         0:       px.coverage = 8'h00;
         1:       px.coverage = 8'hFF;
         default: px.coverage = 8'($urandom_range(255));
      endcase
      px.row_end = ($urandom_range(7) == 0);
      // block end often closes a row; at other times it shows up alone
      px.block_end = (px.row_end && $urandom_range(3) == 0) || ($urandom_range(31) == 0);
      return px;
   endfunction

   // called at a rising edge; returns at the edge that accepts the word
   task automatic send_pixel(input pixel_word_type px, input blend_word_type want);
      while ($urandom_range(99) < src_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {px.coverage, px.dest};
      req_tlast <= px.row_end;
      req_tuser <= px.block_end;
      do @(negedge clock); while (!req_tready);
      expected_blends.push_back(want);
      @(posedge clock);
   endtask

   task automatic send_predicted(input pixel_word_type px);
      blend_word_type want;
      want.pixel = blend_pixel(cfg_color, cfg_row_mode, px.dest, px.coverage);
      want.row_end = px.row_end;
      want.block_end = px.block_end;
      send_pixel(px, want);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_blends.size() != 0);
   endtask

   task automatic csr_write(input csr_reg_type reg_sel, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // only while nothing is in flight
   task automatic set_blend_config(input logic [31:0] color, input logic row_mode);
      drain_results();
      csr_write(CSR_COLOR, color);
      csr_write(CSR_MODE, {31'd0, row_mode});
      cfg_color = color;
      cfg_row_mode = row_mode;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_results
      blend_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blends.size() == 0) begin
            $error("unexpected word: blended_pixel %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_blends.pop_front();
            if (rsp_tdata !== want.pixel) begin
               $error("blended_pixel: expected %h, got %h", want.pixel, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.row_end) begin
               $error("row_end_out: expected %b, got %b", want.row_end, rsp_tlast);
               mismatch_count++;
            end
            if (rsp_tuser !== want.block_end) begin
               $error("block_end_out: expected %b, got %b", want.block_end, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #6_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      pixel_word_type   px;
      blend_word_type   want;
      directed_row_type row;
      logic [31:0]      color;
      int               phase, setting, n;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, first rows run on the reset settings
      for (n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_table[n];
         if (row.color != cfg_color || row.row_mode != cfg_row_mode)
            set_blend_config(row.color, row.row_mode);
         px.dest = row.dest;
         px.coverage = row.coverage;
         px.row_end = row.row_end;
         px.block_end = row.block_end;
         if (row.hand_checked) begin
            want.pixel = row.want;
            want.row_end = row.row_end;
            want.block_end = row.block_end;
            send_pixel(px, want);
         end else begin
            send_predicted(px);
         end
      end

      // idle mixes: none, sender gaps, receiver stalls, both
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin src_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin src_gap_pct = 62; rsp_stall_pct = 0;  end
            2: begin src_gap_pct = 0;  rsp_stall_pct = 62; end
            default: begin src_gap_pct = 27; rsp_stall_pct = 27; end
         endcase
         for (setting = 0; setting < SETTINGS_PER_PHASE; setting++) begin
            case (setting)
               0:       color = 32'hFFFF_FFFF;
               1:       color = 32'h0000_0000;
               2:       color = {8'hFF, 24'($urandom)};
               3:       color = {8'hFE, 24'($urandom)};
               default: color = $urandom;
            endcase
            set_blend_config(color, 1'((setting + phase) & 1));
            for (n = 0; n < PIXELS_PER_SETTING; n++) begin
               px = random_pixel();
               send_predicted(px);
            end
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
sv/socb_pkg.sv
sv/socb_lane.sv
sv/src_over_constant_color_blend_unit.sv
sim/src_over_constant_color_blend_unit_tb.sv
